>>> sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 16;
  localparam int CountW = 5;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [ValueW-1:0] val;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

>>> sv/sorted_priority_queue_top.sv
// Sorted priority queue top level: one RAM ring of entries and its sequencer.
// An empty peek/dequeue, a full enqueue, an enqueue into an empty queue and the
//   unused code finish straight from idle; a peek/dequeue reads the head (ST_HEAD),
//   and an enqueue reads the head (ST_PRI) and, unless it lands there, scans back (ST_SCAN).
// Throughput: one item at a time; busy is high while the sequencer is out of idle and
//   drops as done is asserted; the backward scan moves one RAM entry per cycle.
// Reset (sync, active high) empties the queue; the RAM itself is not cleared.
module sorted_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type,
  input  logic signed [spq_pkg::ValueW-1:0]     item_value,
  input  logic signed [spq_pkg::PrioW-1:0]      item_priority,
  output logic                                  done,
  output logic signed [spq_pkg::ValueW-1:0]     head_value,
  output logic [1:0]                            status,
  output logic [spq_pkg::CountW-1:0]            entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] Last = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] Full = CW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,   // head entry read is in flight for a peek/dequeue
    ST_PRI,    // head entry read is in flight for an enqueue
    ST_SCAN    // walking back from the tail, moving entries up by one
  } state_t;

  state_t state;

  // Entries live in a ring: logical position j sits at head_ptr + j (mod CAPACITY).
  // A dequeue just advances head_ptr and an enqueue at the head steps it back;
  // only an enqueue further down moves entries.
  logic [AW-1:0]  head_ptr;
  logic [CW-1:0]  count;
  logic [AW-1:0]  phys_j;      // ring address of the entry under compare
  logic           first;       // compare is against the tail entry
  logic           pend_deq;
  spq_pkg::entry_t pend;       // item being inserted

  logic                       accept;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  spq_pkg::entry_t            wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [spq_pkg::EntryW-1:0] rd_raw;
  spq_pkg::entry_t            rd_entry;

  logic [AW-1:0] up_addr;
  logic [AW-1:0] dn_addr;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_addr;
  logic          stop;
  logic          head_first;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign rd_entry = spq_pkg::entry_t'(rd_raw);

  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);

  // ring address arithmetic: neighbors with wrap, and the tail slot
  assign up_addr  = (phys_j == Last) ? '0 : phys_j + AW'(1);
  assign dn_addr  = (phys_j == '0) ? Last : phys_j - AW'(1);
  assign head_inc = (head_ptr == Last) ? '0 : head_ptr + AW'(1);
  assign head_dec = (head_ptr == '0) ? Last : head_ptr - AW'(1);
  assign tail_sum = {1'b0, head_ptr} + (AW+1)'(count_dec);
  assign tail_addr = (tail_sum >= (AW+1)'(CAPACITY)) ?
                     AW'(tail_sum - (AW+1)'(CAPACITY)) : tail_sum[AW-1:0];

  // A tie with the head puts the new item in front of it; that is checked
  // before the scan, so the scan only runs while the head outranks the item.
  assign head_first = (pend.prio >= rd_entry.prio);

  // The tail takes the new item on a tie; anywhere else the item goes in
  // ahead of entries of equal priority.
  assign stop = first ? (rd_entry.prio >= pend.prio) : (rd_entry.prio > pend.prio);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = up_addr;
    wr_data = pend;
    rd_en   = 1'b0;
    rd_addr = dn_addr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (spq_pkg::req_t'(req_type))
            spq_pkg::REQ_ENQ: begin
              if (count == '0) begin
                wr_en   = 1'b1;
                wr_addr = head_ptr;
                wr_data = '{val: item_value, prio: item_priority};
              end else if (count < Full) begin
                rd_en   = 1'b1;
                rd_addr = head_ptr;
              end
            end
            spq_pkg::REQ_DEQ, spq_pkg::REQ_PEEK: begin
              if (count != '0) begin
                rd_en   = 1'b1;
                rd_addr = head_ptr;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PRI: begin
        if (head_first) begin
          wr_en   = 1'b1;              // new head goes in the free slot before the old one
          wr_addr = head_dec;
        end else begin
          rd_en   = 1'b1;
          rd_addr = tail_addr;
        end
      end
      ST_SCAN: begin
        wr_en = 1'b1;
        if (!stop) begin
          wr_data = rd_entry;          // move entry j up to j+1
          rd_en   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  spq_ram #(
    .Width(spq_pkg::EntryW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  // Sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      head_ptr <= '0;
      done     <= 1'b0;
      first    <= 1'b0;
      pend_deq <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pend       <= '{val: item_value, prio: item_priority};
            pend_deq   <= (spq_pkg::req_t'(req_type) == spq_pkg::REQ_DEQ);
            head_value <= '0;
            status     <= spq_pkg::STS_OK;
            entry_count <= spq_pkg::CountW'(count);
            case (spq_pkg::req_t'(req_type))
              spq_pkg::REQ_ENQ: begin
                if (count >= Full) begin
                  done   <= 1'b1;
                  status <= spq_pkg::STS_FULL;
                end else if (count == '0) begin
                  done        <= 1'b1;
                  count       <= count_inc;
                  entry_count <= spq_pkg::CountW'(count_inc);
                end else begin
                  state <= ST_PRI;
                end
              end
              spq_pkg::REQ_DEQ, spq_pkg::REQ_PEEK: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= spq_pkg::STS_EMPTY;
                end else begin
                  state <= ST_HEAD;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_HEAD: begin
          done       <= 1'b1;
          head_value <= rd_entry.val;
          status     <= spq_pkg::STS_OK;
          if (pend_deq) begin
            head_ptr    <= head_inc;
            count       <= count_dec;
            entry_count <= spq_pkg::CountW'(count_dec);
          end else begin
            entry_count <= spq_pkg::CountW'(count);
          end
          state <= ST_IDLE;
        end
        ST_PRI: begin
          if (head_first) begin
            done        <= 1'b1;
            head_ptr    <= head_dec;
            count       <= count_inc;
            entry_count <= spq_pkg::CountW'(count_inc);
            state       <= ST_IDLE;
          end else begin
            phys_j <= tail_addr;
            first  <= 1'b1;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          first <= 1'b0;
          if (stop) begin
            done        <= 1'b1;
            count       <= count_inc;
            entry_count <= spq_pkg::CountW'(count_inc);
            state       <= ST_IDLE;
          end else begin
            phys_j <= dn_addr;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // occupancy never passes capacity
  assert property (@(posedge clk) disable iff (rst) count <= Full)
    else $error("occupancy above capacity");

  // an enqueue into a full queue is reported at once as dropped
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == spq_pkg::REQ_ENQ) && (count == Full)
    |=> done && (status == spq_pkg::STS_FULL) && (count == Full))
    else $error("full enqueue not dropped");

  // the scan only runs on a queue that is neither empty nor full
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (count != '0) && (count < Full))
    else $error("scan on empty or full queue");

  // a dequeue that reads the head takes exactly one entry out
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD) && pend_deq |=> done && (count == CW'($past(count) - CW'(1))))
    else $error("dequeue count wrong");

endmodule

>>> sv/spq_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module spq_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
